// ----- hw/rtl/pal_pkg.sv -----
package pal_pkg;

	localparam int LEVELS      = 4;
	localparam int QUEUE_DEPTH = 8;
	localparam int ID_WIDTH    = 8;
	localparam int LEVEL_W     = 2;
	localparam int HOLD_W      = 8;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOT_W      = $clog2(QUEUE_DEPTH);

	localparam logic [HOLD_W-1:0] HOLDOFF_RESET = HOLD_W'(50);

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ADD  = 1'b1;

	typedef struct packed {
		logic                op;
		logic [LEVEL_W-1:0]  level;
		logic [ID_WIDTH-1:0] id;
		logic                blocked;
		logic                taken;
		logic [ID_WIDTH-1:0] res_id;
		logic [LEVEL_W-1:0]  res_level;
	} pal_cmd_t;

endpackage

// ----- hw/rtl/pal_if.sv -----
interface pal_req_if import pal_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                operation;
	logic [LEVEL_W-1:0]  level;
	logic [ID_WIDTH-1:0] sound_id;

	modport source (output valid, operation, level, sound_id, input ready);
	modport sink (input valid, operation, level, sound_id, output ready);
endinterface

interface pal_play_if import pal_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ID_WIDTH-1:0] play_id;
	logic [LEVEL_W-1:0]  play_level;

	modport source (output valid, play_id, play_level, input ready);
	modport sink (input valid, play_id, play_level, output ready);
endinterface

// ----- hw/rtl/pal_cell.sv -----
module pal_cell import pal_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [LEVEL_W-1:0] idx,
	input  logic               prv_valid,
	input  pal_cmd_t           prv_cmd,
	output logic               nxt_valid,
	output pal_cmd_t           nxt_cmd
);

	logic [ID_WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]    count_q;

	logic [ID_WIDTH-1:0] slot_d [QUEUE_DEPTH];
	logic [CNT_W-1:0]    count_d;
	pal_cmd_t            cmd_d;
	logic                nonempty;
	logic                full;
	logic                dup;

	assign nonempty = (count_q != '0);
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));

	always_comb begin
		dup = 1'b0;
		for (int j = 0; j < QUEUE_DEPTH; j++) begin
			if ((CNT_W'(j) < count_q) && (slot_q[j] == prv_cmd.id)) begin
				dup = 1'b1;
			end
		end
	end

	always_comb begin
		slot_d  = slot_q;
		count_d = count_q;
		cmd_d   = prv_cmd;
		if (prv_valid) begin
			if (prv_cmd.op == OP_ADD) begin
				if (prv_cmd.level > idx) begin
					if (nonempty) begin
						cmd_d.blocked = 1'b1;
					end
				end else if (prv_cmd.level == idx) begin
					if (!prv_cmd.blocked && !dup && !full) begin
						slot_d[count_q[SLOT_W-1:0]] = prv_cmd.id;
						count_d = count_q + CNT_W'(1);
					end
				end else if (!prv_cmd.blocked) begin
					count_d = '0;
				end
			end else if (!prv_cmd.taken && nonempty) begin
				cmd_d.taken     = 1'b1;
				cmd_d.res_id    = slot_q[0];
				cmd_d.res_level = idx;
				for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
					slot_d[j] = slot_q[j+1];
				end
				count_d = count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			nxt_valid <= 1'b0;
		end else begin
			count_q   <= count_d;
			nxt_valid <= prv_valid;
		end
	end

	always_ff @(posedge clk) begin
		slot_q  <= slot_d;
		nxt_cmd <= cmd_d;
	end

endmodule

// ----- hw/rtl/priority_alarm_announcer_queue_core.sv -----
// channel   | dir | handshake   | payload
// request   | in  | valid/ready | operation, level, sound_id
// announce  | out | valid/ready | play_id, play_level
// cfg       | in  | cfg_we      | cfg_wdata = holdoff_ticks
//
// an add, or a tick with the holdoff at zero, walks the row of level cells,
// one registered cell after another: request.ready returns when it leaves
// the last cell, and when the tick announces only once its result has moved
// from the pending register into a free output register, later while an
// earlier result waits; a tick that only counts down the holdoff leaves ready high
// reset empties all levels, clears the holdoff counter, holdoff_ticks = 50
// a stalled announce holds its result; one more result may wait behind it
module priority_alarm_announcer_queue_core import pal_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	pal_req_if.sink           request,
	pal_play_if.source        announce,
	input  logic              cfg_we,
	input  logic [HOLD_W-1:0] cfg_wdata
);

	logic                chain_valid [LEVELS+1];
	pal_cmd_t            chain_cmd   [LEVELS+1];

	logic [HOLD_W-1:0]   holdoff_ticks_q;
	logic [HOLD_W-1:0]   holdoff_q;
	logic                in_flight_q;
	logic                pend_valid_q;
	logic [ID_WIDTH-1:0] pend_id_q;
	logic [LEVEL_W-1:0]  pend_level_q;
	logic                out_valid_q;
	logic [ID_WIDTH-1:0] out_id_q;
	logic [LEVEL_W-1:0]  out_level_q;

	logic                accept;
	logic                inject;
	logic                out_free;

	assign request.ready = !in_flight_q && !pend_valid_q;
	assign accept        = request.valid && request.ready;
	assign inject        = accept && ((request.operation == OP_ADD) || (holdoff_q == '0));
	assign out_free      = !out_valid_q || announce.ready;

	assign announce.valid      = out_valid_q;
	assign announce.play_id    = out_id_q;
	assign announce.play_level = out_level_q;

	always_comb begin
		chain_valid[0]         = inject;
		chain_cmd[0].op        = request.operation;
		chain_cmd[0].level     = request.level;
		chain_cmd[0].id        = request.sound_id;
		chain_cmd[0].blocked   = 1'b0;
		chain_cmd[0].taken     = 1'b0;
		chain_cmd[0].res_id    = '0;
		chain_cmd[0].res_level = '0;
	end

	for (genvar g = 0; g < LEVELS; g++) begin : g_cell
		pal_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (LEVEL_W'(g)),
			.prv_valid (chain_valid[g]),
			.prv_cmd   (chain_cmd[g]),
			.nxt_valid (chain_valid[g+1]),
			.nxt_cmd   (chain_cmd[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_ticks_q <= HOLDOFF_RESET;
			holdoff_q       <= '0;
			in_flight_q     <= 1'b0;
			pend_valid_q    <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				holdoff_ticks_q <= cfg_wdata;
			end
			if (accept && (request.operation == OP_TICK) && (holdoff_q != '0)) begin
				holdoff_q <= holdoff_q - HOLD_W'(1);
			end
			if (inject) begin
				in_flight_q <= 1'b1;
			end
			if (out_free) begin
				out_valid_q <= pend_valid_q;
				if (pend_valid_q) begin
					pend_valid_q <= 1'b0;
				end
			end
			if (chain_valid[LEVELS]) begin
				in_flight_q <= 1'b0;
				if (chain_cmd[LEVELS].taken) begin
					pend_valid_q <= 1'b1;
					holdoff_q    <= holdoff_ticks_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chain_valid[LEVELS]) begin
			pend_id_q    <= chain_cmd[LEVELS].res_id;
			pend_level_q <= chain_cmd[LEVELS].res_level;
		end
		if (out_free && pend_valid_q) begin
			out_id_q    <= pend_id_q;
			out_level_q <= pend_level_q;
		end
	end

endmodule

// ----- hw/rtl/pal_checker.sv -----
module pal_checker import pal_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                req_operation,
	input logic                play_valid,
	input logic                play_ready,
	input logic [ID_WIDTH-1:0] play_id,
	input logic [LEVEL_W-1:0]  play_level
);

	// held result stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		play_valid && !play_ready |=> play_valid && $stable(play_id) && $stable(play_level))
		else $error("announce transaction changed while stalled");

	// an add always walks the cells
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_operation == OP_ADD) |=> !req_ready)
		else $error("request ready right after an add transaction");

	// an add never produces an announcement
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_operation == OP_ADD) |=> !$rose(play_valid))
		else $error("announcement right after an add transaction");

	// a new announcement comes out of a busy block
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(play_valid) |-> !$past(req_ready))
		else $error("announcement appeared while request side was idle");

endmodule

bind priority_alarm_announcer_queue_core pal_checker u_pal_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (request.valid),
	.req_ready     (request.ready),
	.req_operation (request.operation),
	.play_valid    (announce.valid),
	.play_ready    (announce.ready),
	.play_id       (announce.play_id),
	.play_level    (announce.play_level)
);
